/* rtl/ptf_pkg.sv */
// Shared types, codes and constants for the presence tracking block.
`default_nettype none
package ptf_pkg;

  // Config port geometry
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_RADAR_ENABLE  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_SCAN_TIME     = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_HOLD_TIME     = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_LOST_TIME     = 8'd3;
  localparam logic [CfgIdxW-1:0] REG_SEND_INTERVAL = 8'd4;

  // Register reset values
  localparam logic [15:0] SCAN_TIME_RST     = 16'd500;
  localparam logic [15:0] HOLD_TIME_RST     = 16'd3000;
  localparam logic [15:0] LOST_TIME_RST     = 16'd2000;
  localparam logic [15:0] SEND_INTERVAL_RST = 16'd50;

  // LED target levels
  localparam logic [7:0] LVL_OFF   = 8'd0;
  localparam logic [7:0] LVL_SCAN  = 8'd30;
  localparam logic [7:0] LVL_MOVE  = 8'd255;
  localparam logic [7:0] LVL_STILL = 8'd100;

  // Motion class codes
  localparam logic [1:0] MOTION_NONE   = 2'd0;
  localparam logic [1:0] MOTION_MOVING = 2'd1;
  localparam logic [1:0] MOTION_STILL  = 2'd2;

  // Camera event codes
  localparam logic [1:0] CAM_NONE  = 2'd0;
  localparam logic [1:0] CAM_BEGIN = 2'd1;
  localparam logic [1:0] CAM_END   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_TRACK = 2'd2,
    ST_LOST  = 2'd3
  } ptf_state_t;

  typedef struct packed {
    logic        radar_enable;
    logic [15:0] scan_time;
    logic [15:0] hold_time;
    logic [15:0] lost_time;
    logic [15:0] send_interval;
  } ptf_cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        report_valid;
    logic        presence;
    logic        moving;
    logic        still;
  } ptf_in_t;

  typedef struct packed {
    logic [7:0]  led_level;
    logic        report_done;
    logic [1:0]  fsm_state;
    logic        active;
    logic [1:0]  motion_class;
    logic [7:0]  target_level;
    logic [31:0] heartbeat;
    logic        send_due;
    logic [1:0]  camera_event;
  } ptf_out_t;

  // Tracker results for one beat, ahead of the LED ramp
  typedef struct packed {
    logic [7:0]  goal;
    logic        report_done;
    logic [1:0]  fsm_state;
    logic        active;
    logic [1:0]  motion_class;
    logic [31:0] heartbeat;
    logic        send_due;
    logic [1:0]  camera_event;
  } ptf_trk_t;

endpackage
`default_nettype wire

/* rtl/ptf_tracker.sv */
// Presence state machine, timers, heartbeat, send limiter and camera events.
`default_nettype none
module ptf_tracker
  import ptf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire ptf_cfg_t cfg,
  input  wire ptf_in_t  beat,
  output ptf_trk_t      trk
);

  ptf_state_t  mode, mode_next;
  logic [31:0] scan_start_ms;
  logic [31:0] last_detect_ms;
  logic [31:0] last_send_ms;
  logic [7:0]  level_goal;
  logic [31:0] report_count;
  logic        prev_presence;

  logic        upd;
  logic        load_scan_start;
  logic        load_detect;
  logic [7:0]  goal_sel;
  logic [7:0]  goal_next;
  logic        scan_done;
  logic        hold_over;
  logic        lost_over;
  logic        send_ok;
  logic [31:0] scan_elapsed;
  logic [31:0] detect_elapsed;
  logic [31:0] send_elapsed;

  // A report is processed only while enabled
  assign upd = accept && cfg.radar_enable && beat.report_valid;

  // Wrapping elapsed times against the thresholds
  assign scan_elapsed   = beat.now_ms - scan_start_ms;
  assign detect_elapsed = beat.now_ms - last_detect_ms;
  assign send_elapsed   = beat.now_ms - last_send_ms;
  assign scan_done = scan_elapsed   > {16'd0, cfg.scan_time};
  assign hold_over = detect_elapsed > {16'd0, cfg.hold_time};
  assign lost_over = detect_elapsed > {16'd0, cfg.lost_time};
  assign send_ok   = send_elapsed   > {16'd0, cfg.send_interval};

  // Next state and timestamp loads
  always_comb begin
    mode_next       = mode;
    load_scan_start = 1'b0;
    load_detect     = 1'b0;
    case (mode)
      ST_IDLE: begin
        if (beat.presence) begin
          mode_next       = ST_SCAN;
          load_scan_start = 1'b1;
        end
      end
      ST_SCAN: begin
        if (beat.presence && scan_done) begin
          mode_next   = ST_TRACK;
          load_detect = 1'b1;
        end else if (!beat.presence) begin
          mode_next = ST_IDLE;
        end
      end
      ST_TRACK: begin
        if (beat.presence) begin
          load_detect = 1'b1;
        end else if (hold_over) begin
          mode_next = ST_LOST;
        end
      end
      ST_LOST: begin
        if (beat.presence) begin
          mode_next   = ST_TRACK;
          load_detect = 1'b1;
        end else if (lost_over) begin
          mode_next = ST_IDLE;
        end
      end
      default: mode_next = ST_IDLE;
    endcase
  end

  // Target level from the state before the transition
  always_comb begin
    case (mode)
      ST_IDLE:  goal_sel = LVL_OFF;
      ST_SCAN:  goal_sel = LVL_SCAN;
      ST_TRACK: goal_sel = beat.moving ? LVL_MOVE : (beat.still ? LVL_STILL : LVL_OFF);
      ST_LOST:  goal_sel = LVL_OFF;
      default:  goal_sel = LVL_OFF;
    endcase
  end

  // Goal: forced off while disabled, held on beats without a report
  always_comb begin
    goal_next = level_goal;
    if (accept && !cfg.radar_enable) begin
      goal_next = LVL_OFF;
    end else if (upd) begin
      goal_next = goal_sel;
    end
  end

  // Per-beat results; all but the goal are zero unless enabled with a report
  always_comb begin
    trk              = '0;
    trk.goal         = goal_next;
    if (cfg.radar_enable && beat.report_valid) begin
      trk.report_done  = 1'b1;
      trk.fsm_state    = mode_next;
      trk.active       = (mode_next == ST_TRACK);
      trk.motion_class = beat.moving ? MOTION_MOVING :
                         (beat.still ? MOTION_STILL : MOTION_NONE);
      trk.heartbeat    = report_count;
      trk.send_due     = send_ok;
      if (beat.presence != prev_presence) begin
        trk.camera_event = beat.presence ? CAM_BEGIN : CAM_END;
      end else begin
        trk.camera_event = CAM_NONE;
      end
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= ST_IDLE;
      scan_start_ms  <= '0;
      last_detect_ms <= '0;
      last_send_ms   <= '0;
      level_goal     <= '0;
      report_count   <= '0;
      prev_presence  <= 1'b0;
    end else begin
      level_goal <= goal_next;
      if (upd) begin
        mode          <= mode_next;
        report_count  <= report_count + 32'd1;
        prev_presence <= beat.presence;
        if (load_scan_start) begin
          scan_start_ms <= beat.now_ms;
        end
        if (load_detect) begin
          last_detect_ms <= beat.now_ms;
        end
        if (send_ok) begin
          last_send_ms <= beat.now_ms;
        end
      end
    end
  end

  // Disabled beats force the goal off
  a_disabled_goal_off: assert property (@(posedge clk) disable iff (rst)
    (!rst && accept && !cfg.radar_enable) |=> (level_goal == LVL_OFF))
    else $error("goal not cleared on disabled beat");

  // State frozen when no report is processed
  a_mode_frozen: assert property (@(posedge clk) disable iff (rst)
    (!rst && !upd) |=> $stable(mode) && $stable(report_count))
    else $error("state moved without a processed report");

  // Heartbeat counts processed reports
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!rst && upd) |=> (report_count == $past(report_count) + 32'd1))
    else $error("report count did not advance");

  // A send-due beat restarts the send interval
  a_send_restart: assert property (@(posedge clk) disable iff (rst)
    (!rst && upd && send_ok) |=> (last_send_ms == $past(beat.now_ms)))
    else $error("send timestamp not captured");

endmodule
`default_nettype wire

/* rtl/presence_tracking_fsm.sv */
// Top level: config registers, handshake, LED ramp and result register.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+--------------------------------
//   input    | in_valid / in_ready          | in_data  (ptf_in_t)
//   output   | out_valid / out_ready        | out_data (ptf_out_t)
//   config   | cfg_we (no wait)             | cfg_index, cfg_data
//
// One beat per cycle while the output is not stalled: the state machine,
// timers and ramp step are computed from the accepted beat and the stored
// state, and the result lands in the output register on the accepting edge.
// in_ready is high whenever the output register is empty or being drained.
// Synchronous reset returns state, config registers and out_valid to defaults.
// A stalled output holds its beat and blocks further input until taken.
`default_nettype none
module presence_tracking_fsm
  import ptf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ptf_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ptf_out_t                 out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  ptf_cfg_t   cfg;
  ptf_trk_t   trk;
  logic [7:0] level_now;
  logic [7:0] level_next;
  logic       in_accept;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radar_enable  <= 1'b1;
      cfg.scan_time     <= SCAN_TIME_RST;
      cfg.hold_time     <= HOLD_TIME_RST;
      cfg.lost_time     <= LOST_TIME_RST;
      cfg.send_interval <= SEND_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADAR_ENABLE:  cfg.radar_enable  <= cfg_data[0];
        REG_SCAN_TIME:     cfg.scan_time     <= cfg_data;
        REG_HOLD_TIME:     cfg.hold_time     <= cfg_data;
        REG_LOST_TIME:     cfg.lost_time     <= cfg_data;
        REG_SEND_INTERVAL: cfg.send_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  ptf_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .cfg    (cfg),
    .beat   (in_data),
    .trk    (trk)
  );

  // LED ramp: one step toward the goal per beat
  always_comb begin
    if (level_now < trk.goal) begin
      level_next = level_now + 8'd1;
    end else if (level_now > trk.goal) begin
      level_next = level_now - 8'd1;
    end else begin
      level_next = level_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_now <= '0;
    end else if (in_accept) begin
      level_now <= level_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.led_level    <= level_next;
      out_data.report_done  <= trk.report_done;
      out_data.fsm_state    <= trk.fsm_state;
      out_data.active       <= trk.active;
      out_data.motion_class <= trk.motion_class;
      out_data.target_level <= trk.report_done ? trk.goal : 8'd0;
      out_data.heartbeat    <= trk.heartbeat;
      out_data.send_due     <= trk.send_due;
      out_data.camera_event <= trk.camera_event;
    end
  end

  // Ramp moves at most one step per beat
  a_ramp_step: assert property (@(posedge clk) disable iff (rst)
    (!rst && in_accept) |=> ((level_now - $past(level_now)) == 8'd0 ||
                             (level_now - $past(level_now)) == 8'd1 ||
                             (level_now - $past(level_now)) == 8'd255))
    else $error("LED level jumped more than one step");

endmodule
`default_nettype wire

/* tb/ptf_tb_pkg.sv */
// Result tracker for the presence tracking testbench: pass predictor and result checks.
package ptf_tb_pkg;
  import ptf_pkg::*;

  class presence_checker;
    // Register copies
    logic        en;
    logic [15:0] scan_t;
    logic [15:0] hold_t;
    logic [15:0] lost_t;
    logic [15:0] send_iv;

    // Predicted block state
    ptf_state_t  mode;
    logic [31:0] scan_start;
    logic [31:0] last_detect;
    logic [31:0] last_send;
    logic [31:0] pass_count;
    logic [7:0]  lvl_now;
    logic [7:0]  lvl_goal;
    logic        prev_pres;

    ptf_out_t    pending_passes[$];
    int unsigned errors;

    function new();
      en          = 1'b1;
      scan_t      = SCAN_TIME_RST;
      hold_t      = HOLD_TIME_RST;
      lost_t      = LOST_TIME_RST;
      send_iv     = SEND_INTERVAL_RST;
      mode        = ST_IDLE;
      scan_start  = '0;
      last_detect = '0;
      last_send   = '0;
      pass_count  = '0;
      lvl_now     = '0;
      lvl_goal    = '0;
      prev_pres   = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_RADAR_ENABLE:  en      = val[0];
        REG_SCAN_TIME:     scan_t  = val;
        REG_HOLD_TIME:     hold_t  = val;
        REG_LOST_TIME:     lost_t  = val;
        REG_SEND_INTERVAL: send_iv = val;
        default: ;
      endcase
    endfunction

    // One LED step toward the goal
    function void step_ramp();
      if (lvl_now < lvl_goal) lvl_now = lvl_now + 8'd1;
      else if (lvl_now > lvl_goal) lvl_now = lvl_now - 8'd1;
    endfunction

    // Expected result for one pass; updates the predicted state
    function ptf_out_t next_pass(ptf_in_t d);
      ptf_out_t    r;
      logic [31:0] since_scan;
      logic [31:0] since_detect;
      logic [31:0] since_send;
      r            = '0;
      since_scan   = d.now_ms - scan_start;
      since_detect = d.now_ms - last_detect;
      since_send   = d.now_ms - last_send;

      // disabled: goal forced off, everything else frozen
      if (!en) begin
        lvl_goal = LVL_OFF;
        step_ramp();
        r.led_level = lvl_now;
        return r;
      end

      if (d.report_valid) begin
        case (mode)
          ST_IDLE: begin
            lvl_goal = LVL_OFF;
            if (d.presence) begin
              mode       = ST_SCAN;
              scan_start = d.now_ms;
            end
          end
          ST_SCAN: begin
            lvl_goal = LVL_SCAN;
            if (d.presence && since_scan > {16'd0, scan_t}) begin
              mode        = ST_TRACK;
              last_detect = d.now_ms;
            end else if (!d.presence) begin
              mode = ST_IDLE;
            end
          end
          ST_TRACK: begin
            lvl_goal = d.moving ? LVL_MOVE : (d.still ? LVL_STILL : LVL_OFF);
            if (d.presence) last_detect = d.now_ms;
            else if (since_detect > {16'd0, hold_t}) mode = ST_LOST;
          end
          default: begin
            lvl_goal = LVL_OFF;
            if (d.presence) begin
              mode        = ST_TRACK;
              last_detect = d.now_ms;
            end else if (since_detect > {16'd0, lost_t}) begin
              mode = ST_IDLE;
            end
          end
        endcase

        r.motion_class = d.moving ? MOTION_MOVING : (d.still ? MOTION_STILL : MOTION_NONE);
        r.heartbeat    = pass_count;
        pass_count     = pass_count + 32'd1;

        // rate limiter
        if (since_send > {16'd0, send_iv}) begin
          last_send  = d.now_ms;
          r.send_due = 1'b1;
        end

        // presence edges for the camera
        if (d.presence != prev_pres) begin
          r.camera_event = d.presence ? CAM_BEGIN : CAM_END;
          prev_pres      = d.presence;
        end

        r.report_done  = 1'b1;
        r.fsm_state    = mode;
        r.active       = (mode == ST_TRACK);
        r.target_level = lvl_goal;
      end

      step_ramp();
      r.led_level = lvl_now;
      return r;
    endfunction

    function void take_pass(ptf_in_t d);
      pending_passes.push_back(next_pass(d));
    endfunction

    function int unsigned outstanding();
      return pending_passes.size();
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t ERROR %s: expected %0h actual %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    // Compare one output beat with the oldest expectation
    function void check_pass(ptf_out_t a);
      ptf_out_t e;
      if (pending_passes.size() == 0) begin
        $display("%0t ERROR unexpected result: expected none actual %h", $time, a);
        errors++;
        return;
      end
      e = pending_passes.pop_front();
      cmp_field("led_level",    32'(e.led_level),    32'(a.led_level));
      cmp_field("report_done",  32'(e.report_done),  32'(a.report_done));
      cmp_field("fsm_state",    32'(e.fsm_state),    32'(a.fsm_state));
      cmp_field("active",       32'(e.active),       32'(a.active));
      cmp_field("motion_class", 32'(e.motion_class), 32'(a.motion_class));
      cmp_field("target_level", 32'(e.target_level), 32'(a.target_level));
      cmp_field("heartbeat",    e.heartbeat,         a.heartbeat);
      cmp_field("send_due",     32'(e.send_due),     32'(a.send_due));
      cmp_field("camera_event", 32'(e.camera_event), 32'(a.camera_event));
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench for presence_tracking_fsm: stimulus, backpressure and checks.
module tb_top;
  import ptf_pkg::*;
  import ptf_tb_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 250;
  localparam int unsigned END_CYCLES  = 10;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ptf_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ptf_out_t            out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  bit          quiet         = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned stall_cycles  = 0;

  // random stimulus state
  logic [31:0] now_cur  = '0;
  bit          pres_run = 1'b0;
  int unsigned run_left = 0;

  presence_checker tracker;

  presence_tracking_fsm dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_pass(out_data);
  end

  // Watchdog: cycles without any beat or write
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random ready bursts, one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // Offer one beat and hold it until accepted
  task automatic send_beat(input ptf_in_t d);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    tracker.take_pass(d);
  endtask

  task automatic send_pass(input logic [31:0] now, input logic rv, input logic p,
                           input logic m, input logic s);
    ptf_in_t d;
    d.now_ms       = now;
    d.report_valid = rv;
    d.presence     = p;
    d.moving       = m;
    d.still        = s;
    send_beat(d);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Sender pause until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // Presence comes in runs; some noise, timestamp jumps and wraps
  task automatic random_pass(input int unsigned step_max);
    ptf_in_t     d;
    int unsigned r;
    if (run_left == 0) begin
      pres_run = 1'($urandom_range(0, 1));
      run_left = $urandom_range(1, 30);
    end
    run_left--;
    r = $urandom_range(0, 99);
    if (r < 2) now_cur = $urandom;
    else if (r < 5) now_cur = now_cur + $urandom_range(0, 70000);
    else now_cur = now_cur + $urandom_range(0, step_max);
    d.now_ms       = now_cur;
    d.report_valid = ($urandom_range(0, 9) != 0);
    d.presence     = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : pres_run;
    d.moving       = 1'($urandom_range(0, 1));
    d.still        = 1'($urandom_range(0, 1));
    send_beat(d);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic run_phase(input logic en, input logic [15:0] sc, input logic [15:0] ho,
                           input logic [15:0] lo, input logic [15:0] si,
                           input int unsigned step_max, input int unsigned n, input bit hold);
    drain_results();
    write_reg(REG_RADAR_ENABLE, {15'd0, en});
    write_reg(REG_SCAN_TIME, sc);
    write_reg(REG_HOLD_TIME, ho);
    write_reg(REG_LOST_TIME, lo);
    write_reg(REG_SEND_INTERVAL, si);
    cfg_we <= 1'b0;
    if (hold) long_hold_req = 1'b1;
    repeat (n) random_pass(step_max);
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed passes on reset register values
    send_pass(32'd0,          1'b0, 1'b0, 1'b0, 1'b0); // no report
    send_pass(32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0, 1'b0); // max stamp, idle
    send_pass(32'd10,         1'b1, 1'b1, 1'b1, 1'b0); // idle to scanning
    send_pass(32'd510,        1'b1, 1'b1, 1'b0, 1'b1); // exactly scan time: stay
    send_pass(32'd511,        1'b1, 1'b1, 1'b1, 1'b1); // to tracking
    send_pass(32'd512,        1'b1, 1'b1, 1'b1, 1'b1); // moving wins
    send_pass(32'd513,        1'b1, 1'b1, 1'b0, 1'b1); // still
    send_pass(32'd514,        1'b1, 1'b0, 1'b0, 1'b0); // presence ended
    send_pass(32'd515,        1'b0, 1'b1, 1'b1, 1'b1); // ramp only
    send_pass(32'd3513,       1'b1, 1'b0, 1'b0, 1'b0); // exactly hold time
    send_pass(32'd3514,       1'b1, 1'b0, 1'b0, 1'b0); // to lost
    send_pass(32'd3600,       1'b1, 1'b1, 1'b0, 1'b1); // lost back to tracking
    send_pass(32'd3700,       1'b1, 1'b0, 1'b0, 1'b0);
    send_pass(32'd6601,       1'b1, 1'b0, 1'b0, 1'b0); // to lost
    send_pass(32'd8601,       1'b1, 1'b0, 1'b1, 1'b0); // lost timeout to idle
    send_pass(32'd8700,       1'b1, 1'b1, 1'b0, 1'b0); // scanning
    send_pass(32'd8701,       1'b1, 1'b0, 1'b0, 1'b0); // presence lost in scan
    send_pass(32'd20,         1'b1, 1'b1, 1'b0, 1'b0); // stamp goes backwards
    send_pass(32'd10,         1'b1, 1'b1, 1'b0, 1'b0); // wrapped elapsed is huge
    send_pass(32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1, 1'b1);

    // Disabled block ignores reports
    drain_results();
    write_reg(REG_RADAR_ENABLE, '0);
    cfg_we <= 1'b0;
    send_pass(32'd100, 1'b1, 1'b1, 1'b1, 1'b0);
    send_pass(32'd200, 1'b0, 1'b0, 1'b0, 1'b0);
    send_pass(32'd300, 1'b1, 1'b0, 1'b0, 1'b1);

    // Random phases across register settings
    run_phase(1'b1, 16'd20, 16'd40, 16'd30, 16'd10, 8, 150, 1'b0);
    run_phase(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 3, 150, 1'b0);
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2000, 150, 1'b0);
    run_phase(1'b1, 16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
              16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)), 40, 150, 1'b1);
    run_phase(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 50, 60, 1'b0);
    run_phase(1'b1, 16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
              16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)), 20, 150, 1'b0);
    run_phase(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 5000, 150,
              1'b0);
    // final stretch at full rate
    quiet = 1'b1;
    run_phase(1'b1, 16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
              16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), 30, 200, 1'b0);

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (tracker.outstanding() != 0) begin
      $display("%0t ERROR results missing: expected %0d more actual 0", $time,
               tracker.outstanding());
      tracker.errors++;
    end
    if (tracker.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/ptf_pkg.sv
rtl/ptf_tracker.sv
rtl/presence_tracking_fsm.sv
tb/ptf_tb_pkg.sv
tb/tb_top.sv
